FILE: design/assert_macros.svh
// Assertion helper macros for the positional list store
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define PLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define PLS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/pls_pkg.sv
// Shared types and constants for the positional list store
package pls_pkg;

  localparam int PLS_CAPACITY   = 32;
  localparam int PLS_DATA_WIDTH = 32;

  // match bits the scanner examines per cycle
  localparam int SCAN_GROUP   = 8;
  localparam int SCAN_GROUP_W = 3;

  typedef enum logic [2:0] {
    K_APPEND = 3'd0,
    K_INSERT = 3'd1,
    K_REMOVE = 3'd2,
    K_FIND   = 3'd3,
    K_READ   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_PUSH = 3'b100
  } state_t;

  // per-cell shift control
  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_stat_t;

endpackage

FILE: design/pls_cell.sv
// One list cell: holds an entry, shifts with its neighbors, compares with the key
module pls_cell #(
  parameter int DATA_WIDTH = pls_pkg::PLS_DATA_WIDTH
) (
  input  logic                  clk,
  input  pls_pkg::cell_ctl_t    ctl,
  input  logic [DATA_WIDTH-1:0] left_q,
  input  logic [DATA_WIDTH-1:0] right_q,
  input  logic [DATA_WIDTH-1:0] new_data,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic                  live,
  output logic [DATA_WIDTH-1:0] q,
  output logic                  match
);
  import pls_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    priority if (ctl.load) begin
      data_nxt = new_data;
    end else if (ctl.take_left) begin
      data_nxt = left_q;
    end else if (ctl.take_right) begin
      data_nxt = right_q;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q     = data_r;
  assign match = live && (data_r == key);

endmodule

FILE: design/pls_scan.sv
// First-match scanner: walks the cell match bits one group per cycle
module pls_scan #(
  parameter  int CAPACITY = pls_pkg::PLS_CAPACITY,
  localparam int N_GRP    = (CAPACITY + pls_pkg::SCAN_GROUP - 1) / pls_pkg::SCAN_GROUP,
  localparam int N_PAD    = N_GRP * pls_pkg::SCAN_GROUP,
  localparam int GRP_W    = (N_GRP > 1) ? $clog2(N_GRP) : 1,
  localparam int FP_RAW   = GRP_W + pls_pkg::SCAN_GROUP_W + 1,
  localparam int FP_W     = (FP_RAW > 6) ? FP_RAW : 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [N_PAD-1:0]    match_in,
  output pls_pkg::scan_stat_t stat,
  output logic [FP_W-1:0]     hit_pos
);
  import pls_pkg::*;

  logic [N_PAD-1:0]        sh_r;
  logic [GRP_W-1:0]        grp_r;
  logic                    active_r;
  logic [SCAN_GROUP-1:0]   low;
  logic [SCAN_GROUP_W-1:0] prio;
  logic                    any;
  logic                    last;

  assign low  = sh_r[SCAN_GROUP-1:0];
  assign any  = |low;
  assign last = (grp_r == GRP_W'(N_GRP - 1));

  // lowest set bit wins
  always_comb begin
    prio = '0;
    for (int i = SCAN_GROUP - 1; i >= 0; i--) begin
      if (low[i]) prio = SCAN_GROUP_W'(i);
    end
  end

  assign stat.done = active_r && (any || last);
  assign stat.hit  = active_r && any;
  assign hit_pos   = FP_W'({grp_r, prio}) + FP_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (start) begin
      active_r <= 1'b1;
    end else if (stat.done) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= match_in;
      grp_r <= '0;
    end else if (active_r) begin
      sh_r  <= sh_r >> SCAN_GROUP;
      grp_r <= grp_r + GRP_W'(1);
    end
  end

endmodule

FILE: design/positional_list_store_top.sv
// Positional list store: a row of shifting cells with a grouped first-match scanner
// Append, insert, remove, read, unused: result goes to a pending register, then to out.
// Find: scanner checks 8 bits per cycle over 1..ceil(CAPACITY/8) groups, up to the first hit.
// One request in flight; a new one is accepted while a finished result waits on out.
// A new request waits until the previous result has moved to the output register; out stalls delay it.
// Reset clears the entry count and control; cell contents are left as they are.
module positional_list_store_top #(
  parameter int CAPACITY   = pls_pkg::PLS_CAPACITY,
  parameter int DATA_WIDTH = pls_pkg::PLS_DATA_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [5:0] position, [37:6] value, [39:38] zero
  input  logic [2:0]  in_tuser,   // [2:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] read_value, [37:32] found_position,
                                  // [43:38] length, [47:44] zero
  output logic [1:0]  out_tuser   // [1:0] status
);
  import pls_pkg::*;

  `include "assert_macros.svh"

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CMP_W  = (CNT_W > 6) ? CNT_W : 6;
  localparam int N_GRP  = (CAPACITY + SCAN_GROUP - 1) / SCAN_GROUP;
  localparam int N_PAD  = N_GRP * SCAN_GROUP;
  localparam int GRP_W  = (N_GRP > 1) ? $clog2(N_GRP) : 1;
  localparam int FP_RAW = GRP_W + SCAN_GROUP_W + 1;
  localparam int FP_W   = (FP_RAW > 6) ? FP_RAW : 6;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  status_t         res_status_r;
  logic [31:0]     res_rd_r;
  logic [5:0]      res_fpos_r;
  logic [5:0]      res_len_r;

  logic            out_tvalid_r;
  status_t         out_status_r;
  logic [31:0]     out_rd_r;
  logic [5:0]      out_fpos_r;
  logic [5:0]      out_len_r;

  logic [5:0]      in_position;
  logic [31:0]     in_value;
  kind_t           in_kind;
  logic            in_fire;
  logic            push;

  logic [DATA_WIDTH-1:0] new_data;
  logic [CMP_W-1:0]      pos_ext, cnt_ext, ins_at, rem_at, cnt_after;
  logic                  full, pos_in_rng;
  logic                  op_ins, op_rem, rd_ok;
  status_t               dec_status;
  logic [IDX_W-1:0]      rd_idx;
  logic [DATA_WIDTH-1:0] rd_sel;
  logic [31:0]           rd_word;

  cell_ctl_t             ctl    [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  logic [CAPACITY-1:0]   cell_match;
  logic [N_PAD-1:0]      match_vec;

  scan_stat_t            scan_st;
  logic [FP_W-1:0]       scan_pos;
  logic                  scan_start;

  assign in_position = in_tdata[5:0];
  assign in_value    = in_tdata[37:6];
  assign in_kind     = kind_t'(in_tuser);
  assign in_tready   = (state_r == S_IDLE);
  assign in_fire     = in_tvalid && in_tready;
  assign new_data    = DATA_WIDTH'(in_value);

  // request decode
  always_comb begin
    pos_ext    = CMP_W'(in_position);
    cnt_ext    = CMP_W'(count_r);
    full       = (cnt_ext == CMP_W'(CAPACITY));
    pos_in_rng = (pos_ext != '0) && (pos_ext <= cnt_ext);
    dec_status = ST_OK;
    op_ins     = 1'b0;
    op_rem     = 1'b0;
    rd_ok      = 1'b0;
    ins_at     = cnt_ext;
    rem_at     = pos_ext - CMP_W'(1);
    unique case (in_kind)
      K_APPEND: begin
        if (full) dec_status = ST_FULL;
        else op_ins = 1'b1;
      end
      K_INSERT: begin
        ins_at = pos_ext;
        if (full) dec_status = ST_FULL;
        else if (pos_ext > cnt_ext) dec_status = ST_BADPOS;
        else op_ins = 1'b1;
      end
      K_REMOVE: begin
        if (!pos_in_rng) dec_status = ST_BADPOS;
        else op_rem = 1'b1;
      end
      K_FIND: begin
        dec_status = ST_OK;
      end
      K_READ: begin
        if (!pos_in_rng) dec_status = ST_BADPOS;
        else rd_ok = 1'b1;
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    cnt_after = cnt_ext;
    if (in_fire && op_ins) cnt_after = cnt_ext + CMP_W'(1);
    else if (in_fire && op_rem) cnt_after = cnt_ext - CMP_W'(1);
    count_nxt = cnt_after[CNT_W-1:0];
  end

  assign rd_idx  = rem_at[IDX_W-1:0];
  assign rd_sel  = cell_q[rd_idx];
  assign rd_word = rd_ok ? 32'($signed(rd_sel)) : 32'd0;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_q;
    logic [DATA_WIDTH-1:0] right_q;

    assign ctl[i].load       = in_fire && op_ins && (CMP_W'(i) == ins_at);
    assign ctl[i].take_left  = in_fire && op_ins && (CMP_W'(i) > ins_at);
    assign ctl[i].take_right = in_fire && op_rem && (CMP_W'(i) >= rem_at);

    if (i == 0) begin : g_first
      assign left_q = new_data;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_q = cell_q[i];
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end

    pls_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl[i]),
      .left_q   (left_q),
      .right_q  (right_q),
      .new_data (new_data),
      .key      (new_data),
      .live     (CMP_W'(i) < cnt_ext),
      .q        (cell_q[i]),
      .match    (cell_match[i])
    );
  end

  assign match_vec  = N_PAD'(cell_match);
  assign scan_start = in_fire && (in_kind == K_FIND);

  pls_scan #(
    .CAPACITY(CAPACITY)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .match_in (match_vec),
    .stat     (scan_st),
    .hit_pos  (scan_pos)
  );

  assign push = (state_r == S_PUSH) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = (in_kind == K_FIND) ? S_SCAN : S_PUSH;
      S_SCAN: if (scan_st.done) state_nxt = S_PUSH;
      S_PUSH: if (push) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (push) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // pending result, then output register
  always_ff @(posedge clk) begin
    if (in_fire && (in_kind != K_FIND)) begin
      res_status_r <= dec_status;
      res_rd_r     <= rd_word;
      res_fpos_r   <= 6'd0;
      res_len_r    <= cnt_after[5:0];
    end else if ((state_r == S_SCAN) && scan_st.done) begin
      res_status_r <= scan_st.hit ? ST_OK : ST_NOTFOUND;
      res_rd_r     <= 32'd0;
      res_fpos_r   <= scan_st.hit ? scan_pos[5:0] : 6'd0;
      res_len_r    <= cnt_ext[5:0];
    end
    if (push) begin
      out_status_r <= res_status_r;
      out_rd_r     <= res_rd_r;
      out_fpos_r   <= res_fpos_r;
      out_len_r    <= res_len_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'd0, out_len_r, out_fpos_r, out_rd_r};
  assign out_tuser  = out_status_r;

  `PLS_NEVER(a_count_bound, (CMP_W'(count_r) > CMP_W'(CAPACITY)), "entry count above capacity")
  `PLS_ASSERT(a_count_on_accept, (count_r != $past(count_r)) |-> $past(in_fire), "count moved")
  `PLS_NEVER(a_scan_in_state, (scan_st.done && (state_r != S_SCAN)), "scan done outside scan")

endmodule
